// ----- hw/rtl/mau_pkg.sv -----
// Shared types, widths and helpers of the attitude update core.
// No dependencies; imported by mau_mul, mau_vnorm and the core top level.
package mau_pkg;

    // serial multiplier operand and product widths
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // handshake between the sequencer and the normalizer
    typedef struct packed {
        logic start;
        logic four;     // 4 components, else 3
    } vn_ctl_t;

    typedef struct packed {
        logic done;
        logic ok;       // vector was nonzero
    } vn_sts_t;

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [31:0] r;
        if (v > PROD_W'(64'sh7fff_ffff))
            r = 32'sh7fff_ffff;
        else if (v < -PROD_W'(64'sh8000_0000))
            r = -32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/mau_mul.sv -----
// Shift-add signed multiplier, one multiplier bit per cycle.
// Depends on mau_pkg.
module mau_mul
    import mau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MUL_W-1:0]  opa,
    input  logic signed [MUL_W-1:0]  opb,
    output logic                     done,
    output logic signed [PROD_W-1:0] prod
);
    localparam int CW = $clog2(MUL_W);

    logic signed [PROD_W-1:0] mcand_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic        [MUL_W-1:0]  mplier_reg;
    logic        [CW-1:0]     cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;
    logic                     last;

    assign last = (cnt_reg == CW'(MUL_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg  <= PROD_W'(opa);
            mplier_reg <= opb;
            acc_reg    <= '0;
            cnt_reg    <= '0;
        end
        else if (busy_reg)
        begin
            // sign bit of the multiplier carries negative weight
            if (mplier_reg[0])
                acc_reg <= last ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            mcand_reg  <= mcand_reg <<< 1;
            mplier_reg <= mplier_reg >> 1;
            cnt_reg    <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ----- hw/rtl/mau_vnorm.sv -----
// Vector normalizer: power-of-two prescale, serial squares, bit-serial
// square root and restoring division. Depends on mau_pkg, mau_mul.
module mau_vnorm
    import mau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  vn_ctl_t                  ctl,
    input  logic signed [PROD_W-1:0] vec [4],
    output vn_sts_t                  sts,
    output logic signed [31:0]       res [4]
);
    typedef enum logic [6:0] {
        V_IDLE = 7'b0000001,
        V_CHK  = 7'b0000010,
        V_SQI  = 7'b0000100,
        V_SQW  = 7'b0001000,
        V_SQRT = 7'b0010000,
        V_DVI  = 7'b0100000,
        V_DVS  = 7'b1000000
    } vstate_t;

    localparam int DN_W = 60;

    vstate_t             state_reg;
    logic [PROD_W-1:0]   mag_reg [4];
    logic [3:0]          neg_reg;
    logic [1:0]          idx_reg;
    logic [63:0]         sum_reg;
    logic [63:0]         sx_reg, sr_reg, sb_reg;
    logic [DN_W-1:0]     dn_reg;
    logic [32:0]         rem_reg;
    logic [5:0]          cnt_reg;
    logic                done_reg, ok_reg;
    logic signed [31:0]  res_reg [4];

    logic [PROD_W-1:0]   mx;
    logic [63:0]         st;
    logic [32:0]         dt;
    logic                dge;
    logic [DN_W-1:0]     dn_next;
    logic                mul_start, mul_done;
    logic signed [PROD_W-1:0] mul_prod;

    always_comb
    begin
        mx = mag_reg[0];
        for (int i = 1; i < 4; i++)
            if (mag_reg[i] > mx)
                mx = mag_reg[i];
    end

    assign st      = sr_reg + sb_reg;
    assign dt      = {rem_reg[31:0], dn_reg[DN_W-1]};
    assign dge     = (dt >= {1'b0, sr_reg[31:0]});
    assign dn_next = {dn_reg[DN_W-2:0], dge};
    assign mul_start = (state_reg == V_SQI);

    mau_mul u_sq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .opa   (MUL_W'(mag_reg[idx_reg][29:0])),
        .opb   (MUL_W'(mag_reg[idx_reg][29:0])),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= V_IDLE;
            done_reg  <= 1'b0;
            ok_reg    <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                V_IDLE: if (ctl.start) state_reg <= V_CHK;
                V_CHK:
                begin
                    if (mx == '0)
                    begin
                        done_reg  <= 1'b1;
                        ok_reg    <= 1'b0;
                        state_reg <= V_IDLE;
                    end
                    else if (mx < PROD_W'(64'h4000_0000) && mx >= PROD_W'(64'h2000_0000))
                        state_reg <= V_SQI;
                end
                V_SQI: state_reg <= V_SQW;
                V_SQW:
                    if (mul_done)
                        state_reg <= (idx_reg == 2'd3) ? V_SQRT : V_SQI;
                V_SQRT: if (sb_reg == 64'd1) state_reg <= V_DVI;
                V_DVI:  state_reg <= V_DVS;
                V_DVS:
                    if (cnt_reg == 6'(DN_W - 1))
                    begin
                        if (idx_reg == 2'd3)
                        begin
                            done_reg  <= 1'b1;
                            ok_reg    <= 1'b1;
                            state_reg <= V_IDLE;
                        end
                        else
                            state_reg <= V_DVI;
                    end
                default: state_reg <= V_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            V_IDLE:
                if (ctl.start)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        neg_reg[i] <= vec[i][PROD_W-1];
                        if (i == 3 && !ctl.four)
                            mag_reg[i] <= '0;
                        else
                            mag_reg[i] <= vec[i][PROD_W-1] ? PROD_W'(-vec[i])
                                                           : PROD_W'(vec[i]);
                    end
                end
            V_CHK:
            begin
                // bring the largest magnitude into [2^29, 2^30)
                if (mx >= PROD_W'(64'h4000_0000))
                    for (int i = 0; i < 4; i++) mag_reg[i] <= mag_reg[i] >> 1;
                else if (mx < PROD_W'(64'h2000_0000))
                    for (int i = 0; i < 4; i++) mag_reg[i] <= mag_reg[i] << 1;
                idx_reg <= '0;
                sum_reg <= '0;
            end
            V_SQI: ;
            V_SQW:
                if (mul_done)
                begin
                    sum_reg <= sum_reg + mul_prod[63:0];
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == 2'd3)
                    begin
                        sx_reg <= sum_reg + mul_prod[63:0];
                        sr_reg <= '0;
                        sb_reg <= 64'h4000_0000_0000_0000;
                    end
                end
            V_SQRT:
            begin
                if (sx_reg >= st)
                begin
                    sx_reg <= sx_reg - st;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end
                else
                    sr_reg <= sr_reg >> 1;
                sb_reg  <= sb_reg >> 2;
                idx_reg <= '0;
            end
            V_DVI:
            begin
                dn_reg  <= {mag_reg[idx_reg][29:0], 30'd0};
                rem_reg <= '0;
                cnt_reg <= '0;
            end
            V_DVS:
            begin
                rem_reg <= dge ? dt - {1'b0, sr_reg[31:0]} : dt;
                dn_reg  <= dn_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == 6'(DN_W - 1))
                begin
                    res_reg[idx_reg] <= neg_reg[idx_reg] ? -dn_next[31:0] : dn_next[31:0];
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign sts.done = done_reg;
    assign sts.ok   = ok_reg;
    assign res      = res_reg;

endmodule

// ----- hw/rtl/mahony_attitude_update_core.sv -----
// Mahony attitude filter core: sequencer, operand table and state.
// Depends on mau_pkg, mau_mul, mau_vnorm.
//
// Usage
//   Input channel (in_valid/in_stall) takes one word per IMU sample:
//   accel, gyro, mag (Q4.28) and time_step (2^-24 s). in_stall is high
//   while a sample is being worked on; a new word is taken only when the
//   sequencer is idle.
//   Output channel (out_valid/out_stall) gives one word per sample: the
//   attitude quaternion (Q2.30) and the updated flag. The result sits in
//   an output register, so the next sample can be taken while it waits.
//   If the receiver still stalls when the following result is finished,
//   the sequencer holds in its final step until the register frees up.
//   Work per sample is set by the sequencer's serial multiplier (49
//   products) and two normalizer passes (one-bit prescale shifts, 4
//   squares on the normalizer's own multiplier, 32-step root, 4
//   divides). A sample whose cross product is zero finishes after the
//   cross product terms and the normalizer's zero check.
//   APB registers: 0x0 prop_gain, 0x4 integ_gain; write only when idle.
//   Reset: attitude is the identity, the error integral is zero, gains
//   return to their defaults and no result is pending.
module mahony_attitude_update_core
    import mau_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] accel_x,
    input  logic signed [31:0] accel_y,
    input  logic signed [31:0] accel_z,
    input  logic signed [31:0] gyro_x,
    input  logic signed [31:0] gyro_y,
    input  logic signed [31:0] gyro_z,
    input  logic signed [31:0] mag_x,
    input  logic signed [31:0] mag_y,
    input  logic signed [31:0] mag_z,
    input  logic [23:0]        time_step,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z,
    output logic               updated
);
    // significant sample bits
    localparam int SW = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int SX = 32 - SW;

    localparam logic [31:0] PROP_RESET = 32'd167772160;

    // operation counter group boundaries
    localparam logic [5:0] OP_H_END   = 6'd5;
    localparam logic [5:0] OP_P_FIRST = 6'd6;
    localparam logic [5:0] OP_P_END   = 6'd15;
    localparam logic [5:0] OP_E_FIRST = 6'd16;
    localparam logic [5:0] OP_E_END   = 6'd27;
    localparam logic [5:0] OP_G_FIRST = 6'd28;
    localparam logic [5:0] OP_Q_END   = 6'd48;

    // product slots q_i*q_j
    localparam int P00 = 0, P11 = 1, P22 = 2, P33 = 3, P01 = 4;
    localparam int P02 = 5, P03 = 6, P12 = 7, P13 = 8, P23 = 9;

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_MI   = 11'b00000000010,
        S_MW   = 11'b00000000100,
        S_VH   = 11'b00000001000,
        S_VHW  = 11'b00000010000,
        S_UW   = 11'b00000100000,
        S_INT  = 11'b00001000000,
        S_VQ   = 11'b00010000000,
        S_VQW  = 11'b00100000000,
        S_FIN  = 11'b01000000000,
        S_HOLD = 11'b10000000000
    } state_t;

    state_t state_reg;
    logic [5:0] op_reg;

    logic [31:0] prop_gain_reg, integ_gain_reg;

    logic signed [31:0] att_reg [4];
    logic signed [31:0] ei_reg [3];
    logic signed [31:0] a_reg [3], g_reg [3], m_reg [3];
    logic [23:0]        dt_reg;
    logic signed [PROD_W-1:0] h_reg [3];
    logic signed [31:0] hn_reg [3];
    logic signed [MUL_W-1:0]  p_reg [10];
    logic signed [31:0] u_reg [3], w_reg [3];
    logic signed [31:0] e_reg [3], d_reg [3];
    logic signed [35:0] nq_reg [4];
    logic signed [PROD_W-1:0] acc_reg;
    logic               upd_reg;

    logic               out_valid_reg, updated_reg;
    logic signed [31:0] qo_reg [4];

    // operand table outputs
    logic signed [MUL_W-1:0]  opa, opb;
    logic [5:0]               sh;
    logic                     neg, beg;
    logic signed [PROD_W-1:0] base;

    logic signed [PROD_W-1:0] mul_prod, sh_prod, acc_next;
    logic                     mul_done, mul_start;

    vn_ctl_t                  vn_ctl;
    vn_sts_t                  vn_sts;
    logic signed [PROD_W-1:0] vn_vec [4];
    logic signed [31:0]       vn_res [4];

    logic in_take, out_take, cfg_wr, res_load;
    logic signed [PROD_W-1:0] uw_t [6];

    function automatic logic signed [31:0] sx(input logic [31:0] v);
        return $signed(v << SX) >>> SX;
    endfunction

    function automatic logic signed [MUL_W-1:0] s34(input logic signed [31:0] v);
        return MUL_W'(v);
    endfunction

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign prdata   = paddr[2] ? integ_gain_reg : prop_gain_reg;

    // finished result moves into the output register once it is free
    assign res_load = ((state_reg == S_FIN) || (state_reg == S_HOLD))
                   && (!out_valid_reg || out_take);

    // ---------------------------------------------------------------
    // operand table: one serial product per step, accumulated into acc
    // ---------------------------------------------------------------
    always_comb
    begin
        opa  = '0;
        opb  = '0;
        sh   = 6'd30;
        neg  = 1'b0;
        beg  = 1'b0;
        base = '0;
        unique case (op_reg)
            // cross product h = a x m
            6'd0:  begin opa = s34(a_reg[1]); opb = s34(m_reg[2]); sh = 6'd0; beg = 1'b1; end
            6'd1:  begin opa = s34(a_reg[2]); opb = s34(m_reg[1]); sh = 6'd0; neg = 1'b1; end
            6'd2:  begin opa = s34(a_reg[2]); opb = s34(m_reg[0]); sh = 6'd0; beg = 1'b1; end
            6'd3:  begin opa = s34(a_reg[0]); opb = s34(m_reg[2]); sh = 6'd0; neg = 1'b1; end
            6'd4:  begin opa = s34(a_reg[0]); opb = s34(m_reg[1]); sh = 6'd0; beg = 1'b1; end
            6'd5:  begin opa = s34(a_reg[1]); opb = s34(m_reg[0]); sh = 6'd0; neg = 1'b1; end
            // quaternion products
            6'd6:  begin opa = s34(att_reg[0]); opb = s34(att_reg[0]); beg = 1'b1; end
            6'd7:  begin opa = s34(att_reg[1]); opb = s34(att_reg[1]); beg = 1'b1; end
            6'd8:  begin opa = s34(att_reg[2]); opb = s34(att_reg[2]); beg = 1'b1; end
            6'd9:  begin opa = s34(att_reg[3]); opb = s34(att_reg[3]); beg = 1'b1; end
            6'd10: begin opa = s34(att_reg[0]); opb = s34(att_reg[1]); beg = 1'b1; end
            6'd11: begin opa = s34(att_reg[0]); opb = s34(att_reg[2]); beg = 1'b1; end
            6'd12: begin opa = s34(att_reg[0]); opb = s34(att_reg[3]); beg = 1'b1; end
            6'd13: begin opa = s34(att_reg[1]); opb = s34(att_reg[2]); beg = 1'b1; end
            6'd14: begin opa = s34(att_reg[1]); opb = s34(att_reg[3]); beg = 1'b1; end
            6'd15: begin opa = s34(att_reg[2]); opb = s34(att_reg[3]); beg = 1'b1; end
            // error terms
            6'd16: begin opa = s34(a_reg[1]);  opb = s34(u_reg[2]); beg = 1'b1; end
            6'd17: begin opa = s34(a_reg[2]);  opb = s34(u_reg[1]); neg = 1'b1; end
            6'd18: begin opa = s34(hn_reg[1]); opb = s34(w_reg[2]); sh = 6'd32; end
            6'd19: begin opa = s34(hn_reg[2]); opb = s34(w_reg[1]); sh = 6'd32; neg = 1'b1; end
            6'd20: begin opa = s34(a_reg[2]);  opb = s34(u_reg[0]); beg = 1'b1; end
            6'd21: begin opa = s34(a_reg[0]);  opb = s34(u_reg[2]); neg = 1'b1; end
            6'd22: begin opa = s34(hn_reg[2]); opb = s34(w_reg[0]); sh = 6'd32; end
            6'd23: begin opa = s34(hn_reg[0]); opb = s34(w_reg[2]); sh = 6'd32; neg = 1'b1; end
            6'd24: begin opa = s34(a_reg[0]);  opb = s34(u_reg[1]); beg = 1'b1; end
            6'd25: begin opa = s34(a_reg[1]);  opb = s34(u_reg[0]); neg = 1'b1; end
            6'd26: begin opa = s34(hn_reg[0]); opb = s34(w_reg[1]); sh = 6'd32; end
            6'd27: begin opa = s34(hn_reg[1]); opb = s34(w_reg[0]); sh = 6'd32; neg = 1'b1; end
            // PI feedback and half-angle increment, per axis
            6'd28: begin opa = MUL_W'(integ_gain_reg); opb = s34(ei_reg[0]); sh = 6'd24;
                         beg = 1'b1; base = PROD_W'(g_reg[0]); end
            6'd29: begin opa = MUL_W'(prop_gain_reg); opb = s34(e_reg[0]); sh = 6'd24; end
            6'd30: begin opa = s34(g_reg[0]); opb = MUL_W'(dt_reg); sh = 6'd23; beg = 1'b1; end
            6'd31: begin opa = MUL_W'(integ_gain_reg); opb = s34(ei_reg[1]); sh = 6'd24;
                         beg = 1'b1; base = PROD_W'(g_reg[1]); end
            6'd32: begin opa = MUL_W'(prop_gain_reg); opb = s34(e_reg[1]); sh = 6'd24; end
            6'd33: begin opa = s34(g_reg[1]); opb = MUL_W'(dt_reg); sh = 6'd23; beg = 1'b1; end
            6'd34: begin opa = MUL_W'(integ_gain_reg); opb = s34(ei_reg[2]); sh = 6'd24;
                         beg = 1'b1; base = PROD_W'(g_reg[2]); end
            6'd35: begin opa = MUL_W'(prop_gain_reg); opb = s34(e_reg[2]); sh = 6'd24; end
            6'd36: begin opa = s34(g_reg[2]); opb = MUL_W'(dt_reg); sh = 6'd23; beg = 1'b1; end
            // quaternion integration
            6'd37: begin opa = s34(att_reg[1]); opb = s34(d_reg[0]); neg = 1'b1;
                         beg = 1'b1; base = PROD_W'(att_reg[0]); end
            6'd38: begin opa = s34(att_reg[2]); opb = s34(d_reg[1]); neg = 1'b1; end
            6'd39: begin opa = s34(att_reg[3]); opb = s34(d_reg[2]); neg = 1'b1; end
            6'd40: begin opa = s34(att_reg[0]); opb = s34(d_reg[0]);
                         beg = 1'b1; base = PROD_W'(att_reg[1]); end
            6'd41: begin opa = s34(att_reg[2]); opb = s34(d_reg[2]); end
            6'd42: begin opa = s34(att_reg[3]); opb = s34(d_reg[1]); neg = 1'b1; end
            6'd43: begin opa = s34(att_reg[0]); opb = s34(d_reg[1]);
                         beg = 1'b1; base = PROD_W'(att_reg[2]); end
            6'd44: begin opa = s34(att_reg[1]); opb = s34(d_reg[2]); neg = 1'b1; end
            6'd45: begin opa = s34(att_reg[3]); opb = s34(d_reg[0]); end
            6'd46: begin opa = s34(att_reg[0]); opb = s34(d_reg[2]);
                         beg = 1'b1; base = PROD_W'(att_reg[3]); end
            6'd47: begin opa = s34(att_reg[1]); opb = s34(d_reg[1]); end
            6'd48: begin opa = s34(att_reg[2]); opb = s34(d_reg[0]); neg = 1'b1; end
            default: ;
        endcase
    end

    assign mul_start = (state_reg == S_MI);
    assign sh_prod   = mul_prod >>> sh;
    assign acc_next  = (beg ? base : acc_reg) + (neg ? -sh_prod : sh_prod);

    mau_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .opa   (opa),
        .opb   (opb),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // normalizer shared by the cross product and the new quaternion
    always_comb
    begin
        vn_ctl.start = (state_reg == S_VH) || (state_reg == S_VQ);
        vn_ctl.four  = (state_reg == S_VQ);
        if (state_reg == S_VQ)
        begin
            for (int i = 0; i < 4; i++)
                vn_vec[i] = PROD_W'(nq_reg[i]);
        end
        else
        begin
            for (int i = 0; i < 3; i++)
                vn_vec[i] = h_reg[i];
            vn_vec[3] = '0;
        end
    end

    mau_vnorm u_vnorm (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (vn_ctl),
        .vec   (vn_vec),
        .sts   (vn_sts),
        .res   (vn_res)
    );

    // reference axes from the quaternion products
    always_comb
    begin
        uw_t[0] = (PROD_W'(p_reg[P13]) - PROD_W'(p_reg[P02])) <<< 1;
        uw_t[1] = (PROD_W'(p_reg[P01]) + PROD_W'(p_reg[P23])) <<< 1;
        uw_t[2] = PROD_W'(p_reg[P00]) - PROD_W'(p_reg[P11])
                - PROD_W'(p_reg[P22]) + PROD_W'(p_reg[P33]);
        uw_t[3] = (PROD_W'(p_reg[P12]) + PROD_W'(p_reg[P03])) <<< 1;
        uw_t[4] = PROD_W'(p_reg[P00]) - PROD_W'(p_reg[P11])
                + PROD_W'(p_reg[P22]) - PROD_W'(p_reg[P33]);
        uw_t[5] = (PROD_W'(p_reg[P23]) - PROD_W'(p_reg[P01])) <<< 1;
    end

    // ---------------------------------------------------------------
    // control
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= '0;
            out_valid_reg  <= 1'b0;
            prop_gain_reg  <= PROP_RESET;
            integ_gain_reg <= '0;
            att_reg[0]     <= 32'sh4000_0000;
            att_reg[1]     <= '0;
            att_reg[2]     <= '0;
            att_reg[3]     <= '0;
            for (int i = 0; i < 3; i++)
                ei_reg[i] <= '0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2])
                    integ_gain_reg <= pwdata;
                else
                    prop_gain_reg <= pwdata;
            end

            if (res_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                    if (in_take)
                    begin
                        op_reg    <= '0;
                        state_reg <= S_MI;
                    end
                S_MI: state_reg <= S_MW;
                S_MW:
                    if (mul_done)
                    begin
                        op_reg <= op_reg + 1'b1;
                        priority if (op_reg == OP_H_END)  state_reg <= S_VH;
                        else if (op_reg == OP_P_END)      state_reg <= S_UW;
                        else if (op_reg == OP_E_END)      state_reg <= S_INT;
                        else if (op_reg == OP_Q_END)      state_reg <= S_VQ;
                        else                              state_reg <= S_MI;
                    end
                S_VH: state_reg <= S_VHW;
                S_VHW:
                    if (vn_sts.done)
                    begin
                        op_reg    <= OP_P_FIRST;
                        state_reg <= vn_sts.ok ? S_MI : S_FIN;
                    end
                S_UW:
                begin
                    op_reg    <= OP_E_FIRST;
                    state_reg <= S_MI;
                end
                S_INT:
                begin
                    if (integ_gain_reg != '0)
                        for (int i = 0; i < 3; i++)
                            ei_reg[i] <= sat32(PROD_W'(ei_reg[i]) + PROD_W'(e_reg[i]));
                    op_reg    <= OP_G_FIRST;
                    state_reg <= S_MI;
                end
                S_VQ: state_reg <= S_VQW;
                S_VQW:
                    if (vn_sts.done)
                    begin
                        // an exactly zero new quaternion keeps the old attitude
                        if (vn_sts.ok)
                            for (int i = 0; i < 4; i++)
                                att_reg[i] <= vn_res[i];
                        state_reg <= S_FIN;
                    end
                S_FIN:
                    if (res_load)
                        state_reg <= S_IDLE;
                    else
                        state_reg <= S_HOLD;
                S_HOLD:
                    if (res_load)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // datapath registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg[0] <= sx(accel_x);
            a_reg[1] <= sx(accel_y);
            a_reg[2] <= sx(accel_z);
            g_reg[0] <= sx(gyro_x);
            g_reg[1] <= sx(gyro_y);
            g_reg[2] <= sx(gyro_z);
            m_reg[0] <= sx(mag_x);
            m_reg[1] <= sx(mag_y);
            m_reg[2] <= sx(mag_z);
            dt_reg   <= time_step;
            upd_reg  <= 1'b0;
        end

        if (state_reg == S_MW && mul_done)
        begin
            acc_reg <= acc_next;
            if (op_reg >= OP_P_FIRST && op_reg <= OP_P_END)
                p_reg[4'(op_reg - OP_P_FIRST)] <= acc_next[MUL_W-1:0];
            unique case (op_reg)
                6'd1:  h_reg[0]  <= acc_next;
                6'd3:  h_reg[1]  <= acc_next;
                6'd5:  h_reg[2]  <= acc_next;
                6'd19: e_reg[0]  <= sat32(acc_next);
                6'd23: e_reg[1]  <= sat32(acc_next);
                6'd27: e_reg[2]  <= sat32(acc_next);
                6'd29: g_reg[0]  <= sat32(acc_next);
                6'd32: g_reg[1]  <= sat32(acc_next);
                6'd35: g_reg[2]  <= sat32(acc_next);
                6'd30: d_reg[0]  <= sat32(acc_next);
                6'd33: d_reg[1]  <= sat32(acc_next);
                6'd36: d_reg[2]  <= sat32(acc_next);
                6'd39: nq_reg[0] <= acc_next[35:0];
                6'd42: nq_reg[1] <= acc_next[35:0];
                6'd45: nq_reg[2] <= acc_next[35:0];
                6'd48: nq_reg[3] <= acc_next[35:0];
                default: ;
            endcase
        end

        if (state_reg == S_VHW && vn_sts.done && vn_sts.ok)
        begin
            for (int i = 0; i < 3; i++)
                hn_reg[i] <= vn_res[i];
            upd_reg <= 1'b1;
        end

        if (state_reg == S_UW)
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= sat32(uw_t[i]);
                w_reg[i] <= sat32(uw_t[i + 3]);
            end

        if (res_load)
        begin
            for (int i = 0; i < 4; i++)
                qo_reg[i] <= att_reg[i];
            updated_reg <= upd_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign quat_w    = qo_reg[0];
    assign quat_x    = qo_reg[1];
    assign quat_y    = qo_reg[2];
    assign quat_z    = qo_reg[3];
    assign updated   = updated_reg;

endmodule

// ----- hw/rtl/mau_checker.sv -----
// Port-level checks of the attitude update core, bound to the top level.
// Depends on mahony_attitude_update_core ports only.
module mau_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] quat_w,
    input logic [31:0] quat_x,
    input logic [31:0] quat_y,
    input logic [31:0] quat_z
);
    // a stalled result word stays valid and its quat_w and quat_z hold
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(quat_w) && $stable(quat_z))
        else $error("stalled result changed");

    // an accepted sample makes the core busy
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("core not busy after accept");

    // the core only turns busy because of an accepted sample
    a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(in_valid))
        else $error("busy without a sample");

    // a reported attitude is never the zero quaternion
    a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (quat_w != 32'd0) || (quat_x != 32'd0)
                   || (quat_y != 32'd0) || (quat_z != 32'd0))
        else $error("zero quaternion reported");

endmodule

bind mahony_attitude_update_core mau_checker u_mau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .quat_w    (quat_w),
    .quat_x    (quat_x),
    .quat_y    (quat_y),
    .quat_z    (quat_z)
);

// ----- test/tb_mahony_attitude_update_core.sv -----
// Testbench for mahony_attitude_update_core: random and directed IMU samples,
// results checked against a built-in fixed point predictor of the filter.
// Depends on mau_pkg and the core RTL only.
`timescale 1ns / 100ps

module tb_mahony_attitude_update_core;
    import mau_pkg::*;

    // APB register map
    localparam logic [2:0] REG_PROP_GAIN  = 3'h0;
    localparam logic [2:0] REG_INTEG_GAIN = 3'h4;

    localparam int IDLE_LIMIT   = 40000;  // > one sample latency plus worst stall
    localparam int DRAIN_CYCLES = 3000;

    typedef struct packed {
        logic signed [31:0] ax, ay, az;
        logic signed [31:0] gx, gy, gz;
        logic signed [31:0] mx, my, mz;
        logic [23:0]        dt;
    } imu_word_t;

    typedef struct packed {
        logic signed [31:0] qw, qx, qy, qz;
        logic               upd;
    } att_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic signed [31:0] accel_x = '0, accel_y = '0, accel_z = '0;
    logic signed [31:0] gyro_x = '0, gyro_y = '0, gyro_z = '0;
    logic signed [31:0] mag_x = '0, mag_y = '0, mag_z = '0;
    logic [23:0]        time_step = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] quat_w, quat_x, quat_y, quat_z;
    logic               updated;

    always #5 clk = ~clk;

    mahony_attitude_update_core uut (.*);

    // ---------------------------------------------------------------
    // Predictor state: mirrors the core's registers and filter state
    // ---------------------------------------------------------------
    logic [31:0]        gain_p = 32'd167772160;
    logic [31:0]        gain_i = 32'd0;
    logic signed [31:0] att_q[4];
    logic signed [31:0] err_int[3];

    att_word_t attitude_q[$];   // expected attitude words, oldest first
    int  fail_cnt = 0;
    int  burst_left = 0;

    function automatic longint clamp32(input longint v);
        if (v > 64'sh7fff_ffff) return 64'sh7fff_ffff;
        if (v < -64'sh8000_0000) return -64'sh8000_0000;
        return v;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'h1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // scale to unit length in Q2.30; returns 0 for the all-zero vector
    function automatic bit unit_vec(input logic signed [65:0] v[4], input int n,
                                    output logic signed [31:0] o[4]);
        logic [65:0] mg[4];
        logic [65:0] top;
        logic [63:0] sum, nr, r;
        int len;
        top = 0;
        sum = 0;
        len = 0;
        for (int i = 0; i < 4; i++) o[i] = 0;
        for (int i = 0; i < n; i++) begin
            mg[i] = v[i] < 0 ? -v[i] : v[i];
            if (mg[i] > top) top = mg[i];
        end
        if (top == 0) return 0;
        while (len < 66 && (top >> len) != 0) len++;
        for (int i = 0; i < n; i++) begin
            mg[i] = len > 30 ? mg[i] >> (len - 30) : mg[i] << (30 - len);
            sum += mg[i][63:0] * mg[i][63:0];
        end
        nr = floor_sqrt(sum);
        for (int i = 0; i < n; i++) begin
            r = (mg[i][63:0] << 30) / nr;
            o[i] = v[i] < 0 ? -r[31:0] : r[31:0];
        end
        return 1;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    // one filter step: updates the predictor state, returns the expected word
    function automatic att_word_t mahony_step(input imu_word_t s);
        longint a[3], g[3], m[3], q[4], p[4][4], u[3], w[3], e[3], d[3];
        logic signed [65:0] h[4], nq[4];
        logic signed [31:0] hn[4], qo[4];
        att_word_t r;
        a = '{longint'(s.ax), longint'(s.ay), longint'(s.az)};
        g = '{longint'(s.gx), longint'(s.gy), longint'(s.gz)};
        m = '{longint'(s.mx), longint'(s.my), longint'(s.mz)};
        // exact cross product, wider than 64 bits
        h[0] = 66'(a[1]) * 66'(m[2]) - 66'(a[2]) * 66'(m[1]);
        h[1] = 66'(a[2]) * 66'(m[0]) - 66'(a[0]) * 66'(m[2]);
        h[2] = 66'(a[0]) * 66'(m[1]) - 66'(a[1]) * 66'(m[0]);
        h[3] = 0;
        r.upd = 1'b0;
        if (unit_vec(h, 3, hn)) begin
            r.upd = 1'b1;
            for (int i = 0; i < 4; i++) q[i] = att_q[i];
            for (int i = 0; i < 4; i++)
                for (int j = 0; j < 4; j++) p[i][j] = qmul(q[i], q[j]);
            u[0] = clamp32(2 * (p[1][3] - p[0][2]));
            u[1] = clamp32(2 * (p[0][1] + p[2][3]));
            u[2] = clamp32(p[0][0] - p[1][1] - p[2][2] + p[3][3]);
            w[0] = clamp32(2 * (p[1][2] + p[0][3]));
            w[1] = clamp32(p[0][0] - p[1][1] + p[2][2] - p[3][3]);
            w[2] = clamp32(2 * (p[2][3] - p[0][1]));
            e[0] = clamp32(((a[1] * u[2]) >>> 30) - ((a[2] * u[1]) >>> 30)
                 + ((longint'(hn[1]) * w[2]) >>> 32) - ((longint'(hn[2]) * w[1]) >>> 32));
            e[1] = clamp32(((a[2] * u[0]) >>> 30) - ((a[0] * u[2]) >>> 30)
                 + ((longint'(hn[2]) * w[0]) >>> 32) - ((longint'(hn[0]) * w[2]) >>> 32));
            e[2] = clamp32(((a[0] * u[1]) >>> 30) - ((a[1] * u[0]) >>> 30)
                 + ((longint'(hn[0]) * w[1]) >>> 32) - ((longint'(hn[1]) * w[0]) >>> 32));
            for (int i = 0; i < 3; i++) begin
                if (gain_i != 0) begin
                    err_int[i] = clamp32(longint'(err_int[i]) + e[i]);
                    g[i] += (longint'(gain_i) * longint'(err_int[i])) >>> 24;
                end
                g[i] += (longint'(gain_p) * e[i]) >>> 24;
                g[i] = clamp32(g[i]);
                d[i] = clamp32((g[i] * longint'(s.dt)) >>> 23);
            end
            nq[0] = q[0] - qmul(q[1], d[0]) - qmul(q[2], d[1]) - qmul(q[3], d[2]);
            nq[1] = q[1] + qmul(q[0], d[0]) + qmul(q[2], d[2]) - qmul(q[3], d[1]);
            nq[2] = q[2] + qmul(q[0], d[1]) - qmul(q[1], d[2]) + qmul(q[3], d[0]);
            nq[3] = q[3] + qmul(q[0], d[2]) + qmul(q[1], d[1]) - qmul(q[2], d[0]);
            // an all-zero quaternion leaves the attitude alone
            if (unit_vec(nq, 4, qo))
                for (int i = 0; i < 4; i++) att_q[i] = qo[i];
        end
        r.qw = att_q[0];
        r.qx = att_q[1];
        r.qy = att_q[2];
        r.qz = att_q[3];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender side: bursts of words with random gaps between them
    // ---------------------------------------------------------------
    task automatic send_word(input imu_word_t s);
        if (burst_left == 0) begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 6);
        end
        else @(negedge clk);
        in_valid = 1'b1;
        {accel_x, accel_y, accel_z} = {s.ax, s.ay, s.az};
        {gyro_x, gyro_y, gyro_z}    = {s.gx, s.gy, s.gz};
        {mag_x, mag_y, mag_z}       = {s.mx, s.my, s.mz};
        time_step = s.dt;
        do @(posedge clk); while (in_stall);
        attitude_q.push_back(mahony_step(s));
        burst_left--;
    endtask

    // hold off until every result is back; registers are only written here
    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        burst_left = 0;
        while (attitude_q.size() != 0) @(negedge clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
        paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == REG_PROP_GAIN) gain_p = data;
        else gain_i = data;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic set_gains(input logic [31:0] kp, input logic [31:0] ki);
        wait_idle();
        apb_write(REG_PROP_GAIN, kp);
        apb_write(REG_INTEG_GAIN, ki);
    endtask

    function automatic logic signed [31:0] near(input int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    // plausible sample: accel within +-1 g per axis, moderate field, small rates, step below 2.4 ms
    function automatic imu_word_t sane_word();
        imu_word_t s;
        s.ax = near(1 << 28); s.ay = near(1 << 28); s.az = near(1 << 28);
        s.mx = near(1 << 27); s.my = near(1 << 27); s.mz = near(1 << 27);
        s.gx = near(1 << 26); s.gy = near(1 << 26); s.gz = near(1 << 26);
        s.dt = $urandom_range(0, 40000);
        return s;
    endfunction

    function automatic imu_word_t noise_word();
        imu_word_t s;
        s = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, 24'($urandom)};
        return s;
    endfunction

    function automatic imu_word_t mk(input logic signed [31:0] ax, ay, az,
                                     gx, gy, gz, mx, my, mz, input logic [23:0] dt);
        imu_word_t s;
        s = {ax, ay, az, gx, gy, gz, mx, my, mz, dt};
        return s;
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    localparam logic signed [31:0] ONE  = 32'sh1000_0000;   // 1.0 in Q4.28
    localparam logic signed [31:0] PMAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] NMAX = 32'sh8000_0000;

    task automatic test_directed();
        // level and still, field north: cross product nonzero
        send_word(mk(0, 0, ONE, 0, 0, 0, ONE, 0, 0, 24'd16777));
        // zero cross product: field parallel to gravity, zero accel, zero field
        send_word(mk(0, 0, ONE, 1000, 2000, 3000, 0, 0, ONE >>> 1, 24'd16777));
        send_word(mk(0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE, 24'hffffff));
        send_word(mk(ONE, 0, 0, 0, 0, 0, 0, 0, 0, 24'd1000));
        // rotation with rates, short and longest step, zero step
        send_word(mk(ONE >>> 2, 0, ONE, ONE, -ONE, ONE >>> 1, 0, ONE, 0, 24'd16777));
        send_word(mk(0, ONE, 0, 0, 0, ONE, ONE, 0, ONE, 24'hffffff));
        send_word(mk(ONE, ONE, 0, PMAX, PMAX, PMAX, 0, ONE, ONE, 24'd0));
        // extreme inputs: cross product near the signed 64-bit limit
        send_word(mk(NMAX, PMAX, NMAX, NMAX, NMAX, NMAX, PMAX, NMAX, PMAX, 24'hffffff));
        send_word(mk(NMAX, NMAX, NMAX, PMAX, PMAX, PMAX, NMAX, PMAX, NMAX, 24'h800000));
        send_word(mk(PMAX, PMAX, PMAX, NMAX, PMAX, NMAX, NMAX, NMAX, PMAX, 24'h000001));
        send_word(mk(-1, 1, -1, -1, -1, -1, 1, 1, -1, 24'hffffff));
        // large rate over long step: attitude may collapse toward zero
        send_word(mk(0, 0, ONE, PMAX, 0, 0, ONE, 0, 0, 24'hffffff));
        send_word(mk(0, 0, ONE, NMAX, NMAX, 0, ONE, 0, 0, 24'hffffff));
    endtask

    task automatic test_integral();
        set_gains(32'd167772160, 32'h0100_0000);
        for (int i = 0; i < 6; i++) send_word(sane_word());
        // error integral driven into saturation
        set_gains(32'd167772160, 32'hffff_ffff);
        for (int i = 0; i < 4; i++)
            send_word(mk(PMAX, NMAX, PMAX, 0, 0, 0, NMAX, PMAX, 0, 24'd100));
    endtask

    task automatic test_gain_extremes();
        set_gains(32'd0, 32'd0);
        for (int i = 0; i < 4; i++) send_word(sane_word());
        set_gains(32'hffff_ffff, 32'hffff_ffff);
        for (int i = 0; i < 4; i++) send_word(sane_word());
        send_word(noise_word());
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++)
            send_word($urandom_range(0, 99) < 85 ? sane_word() : noise_word());
    endtask

    // ---------------------------------------------------------------
    // Receiver stall pattern: long clear stretches, then random stalls
    // ---------------------------------------------------------------
    int stall_run = 0;
    int stall_mode_cnt = 0;
    always @(negedge clk) begin
        stall_mode_cnt <= stall_mode_cnt + 1;
        if (stall_run > 0) begin
            out_stall <= 1'b1;
            stall_run <= stall_run - 1;
        end
        else if ((stall_mode_cnt / 20000) % 3 != 0 && $urandom_range(0, 99) < 4) begin
            out_stall <= 1'b1;
            stall_run <= $urandom_range(0, 80);
        end
        else out_stall <= 1'b0;
    end

    // check each accepted result against the oldest expectation
    always @(posedge clk) begin
        att_word_t x;
        if (rst_n && out_valid && !out_stall) begin
            if (attitude_q.size() == 0) begin
                $error("result with no sample pending");
                fail_cnt++;
            end
            else begin
                x = attitude_q.pop_front();
                if (quat_w !== x.qw) begin
                    $error("quat_w exp %0d got %0d", x.qw, quat_w); fail_cnt++;
                end
                if (quat_x !== x.qx) begin
                    $error("quat_x exp %0d got %0d", x.qx, quat_x); fail_cnt++;
                end
                if (quat_y !== x.qy) begin
                    $error("quat_y exp %0d got %0d", x.qy, quat_y); fail_cnt++;
                end
                if (quat_z !== x.qz) begin
                    $error("quat_z exp %0d got %0d", x.qz, quat_z); fail_cnt++;
                end
                if (updated !== x.upd) begin
                    $error("updated exp %0d got %0d", x.upd, updated); fail_cnt++;
                end
            end
        end
    end

    // watchdog: cycles with no word moving on either channel
    int idle_cycles = 0;
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("mahony_attitude_update_core test failed");
            $finish;
        end
    end

    initial begin
        att_q   = '{32'sh4000_0000, 0, 0, 0};
        err_int = '{0, 0, 0};
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_integral();
        test_gain_extremes();
        set_gains(32'd167772160, 32'd0);
        test_random(150);
        set_gains(32'h0080_0000, 32'h0004_0000);
        test_random(150);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_cnt == 0 && attitude_q.size() == 0)
            $display("mahony_attitude_update_core test passed");
        else
            $display("mahony_attitude_update_core test failed");
        $finish;
    end

endmodule
